// ===== sv/two_group_nearest_match_assert.svh =====
// assertion helpers for the two-group nearest match block
// both expect clk_i and rst_ni in the scope where they are used
`ifndef TWO_GROUP_NEAREST_MATCH_ASSERT_SVH
`define TWO_GROUP_NEAREST_MATCH_ASSERT_SVH

// same-cycle implication
`define TGNM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TGNM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tgnm_pkg.sv =====
`default_nettype none

package tgnm_pkg;

  localparam int ENTRIES = 256;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = ADDR_W + 1;
  localparam int SCORE_W = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // op codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_THR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_SCALE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_CNT  = 2'd3;

  localparam logic [31:0] DIFF_SCALE_RST = 32'h0001_0000;

  typedef struct packed {
    logic               op;
    logic [7:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] entry_cost;
    logic signed [31:0] entry_key;
    logic signed [31:0] query_value;
    logic signed [31:0] query_key;
  } tgnm_in_t;

  typedef struct packed {
    logic [8:0] match_index;
    logic       chose_in_group;
  } tgnm_out_t;

  // one table row
  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] cost;
    logic signed [31:0] key;
  } tgnm_entry_t;

  // travels with a table read through the scoring pipe
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ADDR_W-1:0] idx;
  } tgnm_tag_t;

  typedef struct packed {
    tgnm_tag_t                 tag;
    logic                      grp;
    logic signed [SCORE_W-1:0] score;
  } tgnm_score_t;

  typedef struct packed {
    logic                      done;
    logic                      have_in;
    logic                      have_out;
    logic signed [SCORE_W-1:0] best_in;
    logic signed [SCORE_W-1:0] best_out;
    logic [ADDR_W-1:0]         idx_in;
    logic [ADDR_W-1:0]         idx_out;
  } tgnm_best_t;

endpackage

`default_nettype wire

// ===== sv/tgnm_table.sv =====
`default_nettype none

module tgnm_table (
  input  wire                          clk_i,
  input  wire                          we_i,
  input  wire [tgnm_pkg::ADDR_W-1:0]   waddr_i,
  input  wire tgnm_pkg::tgnm_entry_t   wdata_i,
  input  wire [tgnm_pkg::ADDR_W-1:0]   raddr_i,
  output tgnm_pkg::tgnm_entry_t        rdata_o
);
  import tgnm_pkg::*;

  tgnm_entry_t mem [ENTRIES];
  tgnm_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/tgnm_score.sv =====
`default_nettype none

module tgnm_score (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire tgnm_pkg::tgnm_tag_t   tag_i,
  input  wire tgnm_pkg::tgnm_entry_t entry_i,
  input  wire signed [31:0]          query_value_i,
  input  wire signed [31:0]          query_key_i,
  input  wire signed [31:0]          group_thr_i,
  input  wire [31:0]                 diff_scale_i,
  output tgnm_pkg::tgnm_score_t      score_o
);
  import tgnm_pkg::*;

  localparam logic signed [49:0] SAT_MAX = 50'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] SAT_MIN = -SAT_MAX - 50'sd1;

  // stage a: magnitude of the value difference and group test
  logic signed [32:0] diff_pos, diff_neg, key_diff;
  logic [31:0]        mag_d;
  logic               grp_d;

  tgnm_tag_t          tag_a_q, tag_b_q, tag_c_q;
  logic [31:0]        mag_q;
  logic signed [31:0] cost_a_q, cost_b_q;
  logic               grp_a_q, grp_b_q, grp_c_q;
  logic [63:0]        prod_d, prod_q;
  logic signed [49:0] sum_d;
  logic signed [SCORE_W-1:0] sat_d, score_q;

  always_comb begin
    diff_pos = 33'(query_value_i) - 33'(entry_i.value);
    diff_neg = 33'(entry_i.value) - 33'(query_value_i);
    mag_d    = diff_pos[32] ? diff_neg[31:0] : diff_pos[31:0];
    key_diff = 33'(query_key_i) - 33'(entry_i.key);
    grp_d    = key_diff <= 33'(group_thr_i);
  end

  // stage b: scale
  assign prod_d = mag_q * diff_scale_i;

  // stage c: drop fraction bits, add cost, clamp to 48 bits
  always_comb begin
    sum_d = $signed({2'b00, prod_q[63:16]}) + 50'(cost_b_q);
    if (sum_d > SAT_MAX) begin
      sat_d = SAT_MAX[SCORE_W-1:0];
    end else if (sum_d < SAT_MIN) begin
      sat_d = SAT_MIN[SCORE_W-1:0];
    end else begin
      sat_d = sum_d[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
      tag_c_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
      tag_c_q <= tag_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    cost_a_q <= entry_i.cost;
    grp_a_q  <= grp_d;
    prod_q   <= prod_d;
    cost_b_q <= cost_a_q;
    grp_b_q  <= grp_a_q;
    score_q  <= sat_d;
    grp_c_q  <= grp_b_q;
  end

  assign score_o.tag   = tag_c_q;
  assign score_o.grp   = grp_c_q;
  assign score_o.score = score_q;

endmodule

`default_nettype wire

// ===== sv/tgnm_best.sv =====
`default_nettype none

module tgnm_best (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        clear_i,
  input  wire tgnm_pkg::tgnm_score_t score_i,
  output tgnm_pkg::tgnm_best_t       best_o
);
  import tgnm_pkg::*;

  tgnm_best_t best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q.done <= score_i.tag.valid && score_i.tag.last;
      if (clear_i) begin
        best_q.have_in  <= 1'b0;
        best_q.have_out <= 1'b0;
      end else if (score_i.tag.valid) begin
        // strict compare keeps the earliest entry on ties
        if (score_i.grp) begin
          if (!best_q.have_in || score_i.score < best_q.best_in) begin
            best_q.have_in <= 1'b1;
            best_q.best_in <= score_i.score;
            best_q.idx_in  <= score_i.tag.idx;
          end
        end else begin
          if (!best_q.have_out || score_i.score < best_q.best_out) begin
            best_q.have_out <= 1'b1;
            best_q.best_out <= score_i.score;
            best_q.idx_out  <= score_i.tag.idx;
          end
        end
      end
    end
  end

  assign best_o = best_q;

endmodule

`default_nettype wire

// ===== sv/two_group_nearest_match.sv =====
// two-group nearest match
// input channel (in_valid_i / in_stall_o, payload in_data_i) carries two kinds of
// transaction: a load (op 0) writes value, cost and key into one table slot, a
// query (op 1) scans the first entry_count slots and yields one result on the
// output channel (out_valid_o / out_stall_i, payload out_data_o)
// a load produces no result
// a query reads one slot from the table memory per cycle; each read passes the
// table read register, three scoring stages and the running-best register; the
// drain state waits until the last slot has reached the running best, and the
// decision state loads the output register; the next transaction is taken once
// the block is back in idle; the single table read port sets the scan rate
// the input stalls while a query is in progress; a finished result sits in the
// output register, so a new transaction is taken while that result waits
// a query that finishes while the previous result is still stalled holds in its
// decision state until the output register frees up
// configuration writes (cfg_valid_i / cfg_ready_o) are always taken; write them
// only when no query is in flight
// reset clears the registers to group_threshold 0, accept_threshold 0,
// difference_scale 1.0 and entry_count 1; table contents stay undefined until
// loaded
`default_nettype none

`include "two_group_nearest_match_assert.svh"

module two_group_nearest_match (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire tgnm_pkg::tgnm_in_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output tgnm_pkg::tgnm_out_t                    out_data_o,
  input  wire                                    cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire [tgnm_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire [tgnm_pkg::CFG_DATA_W-1:0]         cfg_data_i
);
  import tgnm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

  state_e state_q;

  // configuration registers
  logic signed [31:0]        group_thr_q;
  logic signed [SCORE_W-1:0] accept_thr_q;
  logic [31:0]               diff_scale_q;
  logic [8:0]                entry_count_q;

  // query context
  logic signed [31:0] query_value_q, query_key_q;
  logic [CNT_W-1:0]   scan_cnt_q;
  logic [CNT_W-1:0]   n_eff;
  logic               scan_last;
  tgnm_tag_t          rd_tag_q;

  logic        out_valid_q;
  tgnm_out_t   out_data_q;

  logic        in_accept, query_accept, load_accept;
  logic        out_free, out_load, pick_in_group;
  logic [ADDR_W-1:0] pick_idx;

  tgnm_entry_t wdata, rdata;
  tgnm_score_t score;
  tgnm_best_t  best;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_thr_q   <= '0;
      accept_thr_q  <= '0;
      diff_scale_q  <= DIFF_SCALE_RST;
      entry_count_q <= 9'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_GROUP_THR:  group_thr_q   <= cfg_data_i[31:0];
        CFG_ACCEPT_THR: accept_thr_q  <= cfg_data_i[SCORE_W-1:0];
        CFG_DIFF_SCALE: diff_scale_q  <= cfg_data_i[31:0];
        CFG_ENTRY_CNT:  entry_count_q <= cfg_data_i[8:0];
      endcase
    end
  end

  // entries searched: zero counts as one, clamp to the table depth
  always_comb begin
    if (entry_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(entry_count_q) > ENTRIES) begin
      n_eff = CNT_W'(ENTRIES);
    end else begin
      n_eff = CNT_W'(entry_count_q);
    end
  end

  assign scan_last = scan_cnt_q == (n_eff - CNT_W'(1));

  assign in_stall_o   = state_q != ST_IDLE;
  assign in_accept    = in_valid_i && !in_stall_o;
  assign query_accept = in_accept && in_data_i.op == OP_QUERY;
  // slots past the table depth are dropped
  assign load_accept  = in_accept && in_data_i.op == OP_LOAD
                        && int'(in_data_i.entry_index) < ENTRIES;

  assign wdata.value = in_data_i.entry_value;
  assign wdata.cost  = in_data_i.entry_cost;
  assign wdata.key   = in_data_i.entry_key;

  tgnm_table u_table (
    .clk_i   (clk_i),
    .we_i    (load_accept),
    .waddr_i (ADDR_W'(in_data_i.entry_index)),
    .wdata_i (wdata),
    .raddr_i (scan_cnt_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  tgnm_score u_score (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tag_i         (rd_tag_q),
    .entry_i       (rdata),
    .query_value_i (query_value_q),
    .query_key_i   (query_key_q),
    .group_thr_i   (group_thr_q),
    .diff_scale_i  (diff_scale_q),
    .score_o       (score)
  );

  tgnm_best u_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (query_accept),
    .score_i (score),
    .best_o  (best)
  );

  // final pick: an empty group hands the win to the other one
  always_comb begin
    if (!best.have_in) begin
      pick_in_group = 1'b0;
    end else if (!best.have_out) begin
      pick_in_group = 1'b1;
    end else begin
      pick_in_group = (best.best_in < accept_thr_q) || (best.best_in < best.best_out);
    end
    pick_idx = pick_in_group ? best.idx_in : best.idx_out;
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = state_q == ST_DECIDE && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      scan_cnt_q    <= '0;
      rd_tag_q      <= '0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      query_value_q <= '0;
      query_key_q   <= '0;
    end else begin
      // a read is issued on every scan cycle
      rd_tag_q.valid <= state_q == ST_SCAN;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (query_accept) begin
            query_value_q <= in_data_i.query_value;
            query_key_q   <= in_data_i.query_key;
            scan_cnt_q    <= '0;
            state_q       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // read issued this cycle, its tag lines up with the registered data
          rd_tag_q.last  <= scan_last;
          rd_tag_q.idx   <= scan_cnt_q[ADDR_W-1:0];
          if (scan_last) begin
            state_q <= ST_DRAIN;
          end else begin
            scan_cnt_q <= scan_cnt_q + CNT_W'(1);
          end
        end
        ST_DRAIN: begin
          if (best.done) begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (out_free) begin
            out_data_q.match_index     <= 9'(pick_idx) + 9'd1;
            out_data_q.chose_in_group  <= pick_in_group;
            state_q                    <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `TGNM_ASSERT_IMP(a_scan_in_range, state_q == ST_SCAN, scan_cnt_q < n_eff, "scan past count")
  `TGNM_ASSERT_NXT(a_query_starts_scan, query_accept, state_q == ST_SCAN, "no scan after query")
  `TGNM_ASSERT_IMP(a_done_in_drain, best.done, state_q == ST_DRAIN, "scan end outside drain")
  `TGNM_ASSERT_IMP(a_pick_nonempty, out_load && pick_in_group, best.have_in, "empty in-group picked")

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import tgnm_pkg::*;

  localparam int PHASES = 12;
  localparam int RESULT_HOLD_CYCLES = 500;
  localparam int LOAD_SETTLE_CYCLES = 16;
  localparam int SETTLE_CYCLES = ENTRIES + 16;
  localparam longint TIMEOUT_NS = 64'd50_000_000;
  localparam longint SCORE_HI = 64'sh7fff_ffff_ffff;
  localparam longint SCORE_LO = -SCORE_HI - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  tgnm_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  tgnm_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  two_group_nearest_match DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the table and registers
  logic signed [31:0] slot_value [ENTRIES];
  logic signed [31:0] slot_cost [ENTRIES];
  logic signed [31:0] slot_key [ENTRIES];
  logic signed [31:0] grp_thr = '0;
  logic signed [47:0] acc_thr = '0;
  logic [31:0] diff_scale = DIFF_SCALE_RST;
  logic [8:0] entry_cnt = 9'd1;

  tgnm_in_t pending_items[$];
  tgnm_out_t expected_matches[$];
  int mismatches = 0;

  // stimulus side bookkeeping
  bit [ENTRIES-1:0] slot_written = '0;
  int gen_span = 1;
  int send_idle_pct = 12;
  int recv_idle_pct = 71;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  function automatic logic signed [47:0] entry_score(logic signed [31:0] qv, int slot);
    logic [32:0] diff;
    logic [32:0] neg;
    logic [31:0] mag;
    logic [63:0] prod;
    longint sum;
    diff = {qv[31], qv} - {slot_value[slot][31], slot_value[slot]};
    neg = -diff;
    mag = diff[32] ? neg[31:0] : diff[31:0];
    prod = {32'b0, mag} * {32'b0, diff_scale};
    sum = longint'(prod >> 16) + longint'(slot_cost[slot]);
    if (sum > SCORE_HI) sum = SCORE_HI;
    if (sum < SCORE_LO) sum = SCORE_LO;
    return sum[47:0];
  endfunction

  function automatic tgnm_out_t predict_match(tgnm_in_t q);
    int span;
    bit have_in;
    bit have_out;
    bit grp;
    logic signed [47:0] best_in;
    logic signed [47:0] best_out;
    logic signed [47:0] s;
    int idx_in;
    int idx_out;
    tgnm_out_t r;
    span = (entry_cnt == 0) ? 1 : ((int'(entry_cnt) > ENTRIES) ? ENTRIES : int'(entry_cnt));
    have_in = 1'b0;
    have_out = 1'b0;
    best_in = '0;
    best_out = '0;
    idx_in = 0;
    idx_out = 0;
    for (int j = 0; j < span; j++) begin
      s = entry_score($signed(q.query_value), j);
      grp = (longint'($signed(q.query_key)) - longint'(slot_key[j])) <= longint'(grp_thr);
      if (grp) begin
        if (!have_in || s < best_in) begin
          best_in = s;
          idx_in = j;
          have_in = 1'b1;
        end
      end else begin
        if (!have_out || s < best_out) begin
          best_out = s;
          idx_out = j;
          have_out = 1'b1;
        end
      end
    end
    // an empty group hands the win to the other one
    if (!have_in) r.chose_in_group = 1'b0;
    else if (!have_out) r.chose_in_group = 1'b1;
    else r.chose_in_group = (best_in < acc_thr) || (best_in < best_out);
    r.match_index = 9'((r.chose_in_group ? idx_in : idx_out) + 1);
    return r;
  endfunction

  // driver: holds a stalled transaction, otherwise offers the next one or idles
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and the occasional long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= RESULT_HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: results, register writes and accepted transactions
  always @(posedge clk_i) begin : monitor
    tgnm_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_matches.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, index %0d in_group %0b", $time,
                   out_data_o.match_index, out_data_o.chose_in_group);
        end else begin
          want = expected_matches.pop_front();
          if (out_data_o.match_index !== want.match_index) begin
            mismatches++;
            $display("%0t: match_index expected %0d actual %0d", $time,
                     want.match_index, out_data_o.match_index);
          end
          if (out_data_o.chose_in_group !== want.chose_in_group) begin
            mismatches++;
            $display("%0t: chose_in_group expected %0b actual %0b", $time,
                     want.chose_in_group, out_data_o.chose_in_group);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_GROUP_THR:  grp_thr = cfg_data_i[31:0];
          CFG_ACCEPT_THR: acc_thr = cfg_data_i[47:0];
          CFG_DIFF_SCALE: diff_scale = cfg_data_i[31:0];
          CFG_ENTRY_CNT:  entry_cnt = cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        if (in_data_i.op == OP_LOAD) begin
          slot_value[in_data_i.entry_index] = in_data_i.entry_value;
          slot_cost[in_data_i.entry_index] = in_data_i.entry_cost;
          slot_key[in_data_i.entry_index] = in_data_i.entry_key;
        end else begin
          expected_matches.push_back(predict_match(in_data_i));
        end
      end
    end
  end

  // Q16.16 values: extremes, exact small multiples for ties, a dense band, full range
  function automatic logic [31:0] draw_q16();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return $urandom();
      4: return 32'h0;
      5: return 32'((int'($urandom_range(6)) - 3) * 65536);
      default: return 32'(int'($urandom_range(8 * 65536)) - 4 * 65536);
    endcase
  endfunction

  function automatic logic [47:0] draw_accept();
    logic [31:0] v;
    v = draw_q16();
    case ($urandom_range(5))
      0: return 48'h7fff_ffff_ffff;
      1: return 48'h8000_0000_0000;
      2: return 48'({$urandom(), $urandom()} >> 16);
      3: return {{16{v[31]}}, v};
      default: return 48'(int'($urandom_range(16 * 65536)) - 8 * 65536);
    endcase
  endfunction

  function automatic logic [31:0] draw_scale();
    case ($urandom_range(5))
      0: return DIFF_SCALE_RST;
      1: return 32'h0;
      2: return 32'hffff_ffff;
      3: return $urandom();
      default: return $urandom_range(4 * 65536);
    endcase
  endfunction

  task automatic queue_load(int slot, logic [31:0] value, logic [31:0] cost, logic [31:0] key);
    tgnm_in_t t;
    t.op = OP_LOAD;
    t.entry_index = 8'(slot);
    t.entry_value = value;
    t.entry_cost = cost;
    t.entry_key = key;
    t.query_value = $urandom();
    t.query_key = $urandom();
    slot_written[slot] = 1'b1;
    pending_items.push_back(t);
  endtask

  task automatic queue_query(logic [31:0] qv, logic [31:0] qk);
    tgnm_in_t t;
    t.op = OP_QUERY;
    t.entry_index = 8'($urandom());
    t.entry_value = $urandom();
    t.entry_cost = $urandom();
    t.entry_key = $urandom();
    t.query_value = qv;
    t.query_key = qk;
    pending_items.push_back(t);
  endtask

  // load every slot of the searched range that has never been written
  task automatic fill_span();
    for (int j = 0; j < gen_span; j++)
      if (!slot_written[j]) queue_load(j, draw_q16(), draw_q16(), draw_q16());
  endtask

  // sampled at the falling edge so the check never races the driver or monitor
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_matches.size() != 0);
    repeat (LOAD_SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // caller sits at a rising edge; valid stays up between back-to-back writes
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
  endtask

  // unused upper data bits carry junk, the block only looks at the register width
  task automatic apply_settings(logic [31:0] gthr, logic [47:0] athr, logic [31:0] scale,
                                logic [8:0] cnt);
    write_reg(CFG_GROUP_THR, {16'($urandom()), gthr});
    write_reg(CFG_ACCEPT_THR, athr);
    write_reg(CFG_DIFF_SCALE, {16'($urandom()), scale});
    write_reg(CFG_ENTRY_CNT, {39'($urandom()), cnt});
    cfg_valid_i <= 1'b0;
    gen_span = (cnt == 0) ? 1 : ((int'(cnt) > ENTRIES) ? ENTRIES : int'(cnt));
  endtask

  initial begin : sequencer
    int phase_items;
    int slot;
    logic [31:0] gthr;
    logic [31:0] scale;
    logic [47:0] athr;
    logic [8:0] cnt;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of value, cost and key, a tie between slots 0 and 3
    apply_settings(32'h0, 48'h0, DIFF_SCALE_RST, 9'd4);
    queue_load(0, 32'h0, 32'h0, 32'h0);
    queue_load(1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_load(2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_load(3, 32'h0, 32'h0, 32'h0);
    queue_load(255, 32'h0001_8000, 32'hffff_0000, 32'h0002_0000);
    queue_query(32'h0, 32'h0);
    queue_query(32'h8000_0000, 32'h8000_0000);
    queue_query(32'h7fff_ffff, 32'h7fff_ffff);
    queue_query(32'h0, 32'h0001_0000);
    queue_query(32'h0000_8000, 32'hffff_0000);
    wait_idle();

    // full-scale factor drives scores into saturation
    apply_settings(32'h0, 48'h0, 32'hffff_ffff, 9'd4);
    queue_query(32'h7fff_ffff, 32'h0);
    queue_query(32'h8000_0000, 32'h0);
    wait_idle();

    // in-group winner accepted outright by the threshold
    apply_settings(32'h0, 48'h7fff_ffff_ffff, DIFF_SCALE_RST, 9'd4);
    queue_query(32'h7fff_ffff, 32'h7fff_ffff);
    queue_query(32'h8000_0000, 32'h0);
    wait_idle();

    // single entry: empty in-group, then empty out-of-group
    apply_settings(32'h0, 48'h0, DIFF_SCALE_RST, 9'd1);
    queue_query(32'h0, 32'h7fff_ffff);
    queue_query(32'h0, 32'h0);
    queue_query(32'h0, 32'h8000_0000);
    wait_idle();

    for (int k = 0; k < PHASES; k++) begin
      if (k == PHASES / 3) begin
        send_idle_pct = 71;
        recv_idle_pct = 12;
      end else if (k == 2 * PHASES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      gthr = draw_q16();
      athr = draw_accept();
      scale = draw_scale();
      cnt = 9'($urandom_range(2, 24));
      case (k)
        0: begin
          athr = 48'h7fff_ffff_ffff;
          scale = 32'h0;
          cnt = 9'd1;
        end
        1: begin
          gthr = 32'h8000_0000;
          athr = 48'h8000_0000_0000;
          scale = 32'hffff_ffff;
          cnt = 9'd256;
        end
        2: begin
          gthr = 32'h7fff_ffff;
          athr = 48'h0;
          scale = DIFF_SCALE_RST;
          cnt = 9'd0;
        end
        3: cnt = 9'd511;
        default: ;
      endcase
      apply_settings(gthr, athr, scale, cnt);
      fill_span();
      phase_items = (gen_span == ENTRIES) ? 60 : 130;
      for (int i = 0; i < phase_items; i++) begin
        if ($urandom_range(99) < 25) begin
          slot = ($urandom_range(3) != 0) ? $urandom_range(gen_span - 1)
                                          : $urandom_range(ENTRIES - 1);
          queue_load(slot, draw_q16(), draw_q16(), draw_q16());
        end else begin
          queue_query(draw_q16(), draw_q16());
        end
      end
      // long receiver hold-off with the sender still busy fills the block
      if (k == PHASES - 3) hold_requests++;
      // sender pauses here until every outstanding result is back
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_matches.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected results never arrived", $time, expected_matches.size());
    end
    if (mismatches == 0) begin
      $display("two_group_nearest_match regression: pass");
    end else begin
      $display("two_group_nearest_match regression: fail");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("two_group_nearest_match regression: fail");
    $finish;
  end

endmodule
